// ===== src/x86_flags_unit_assert.svh =====
// Assertion macros for the x86 flags unit.
// Users must have clk and rst in scope; no other dependencies.
`ifndef X86_FLAGS_UNIT_ASSERT_SVH
`define X86_FLAGS_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define X86F_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define X86F_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/x86f_pkg.sv =====
// Shared types, codes and width helpers for the x86 flags unit.
// No dependencies.
`timescale 1ns / 1ps

package x86f_pkg;

  localparam int DataWidth = 64;
  localparam int WordBits = 64;
  localparam logic [WordBits-1:0] FlagsFixedBits = 64'h202;

  localparam int CfPos = 0;
  localparam int PfPos = 2;
  localparam int AfPos = 4;
  localparam int ZfPos = 6;
  localparam int SfPos = 7;
  localparam int DfPos = 10;
  localparam int OfPos = 11;

  typedef enum logic [2:0] {
    ActAdd   = 3'd0,
    ActSub   = 3'd1,
    ActLogic = 3'd2,
    ActCond  = 3'd3,
    ActRead  = 3'd4,
    ActWrite = 3'd5
  } action_t;

  typedef enum logic [2:0] {
    TestO  = 3'd0,
    TestC  = 3'd1,
    TestZ  = 3'd2,
    TestBe = 3'd3,
    TestS  = 3'd4,
    TestP  = 3'd5,
    TestL  = 3'd6,
    TestLe = 3'd7
  } cond_test_t;

  typedef struct packed {
    logic cf;
    logic pf;
    logic af;
    logic zf;
    logic sf;
    logic df;
    logic of;
  } flags_t;

  typedef struct packed {
    logic [2:0]          action;
    logic [1:0]          operand_size;
    logic [WordBits-1:0] left_operand;
    logic [WordBits-1:0] right_operand;
    logic [WordBits-1:0] result_value;
    logic                keep_carry;
    logic                zero_from_compare;
    logic [3:0]          condition_code;
    logic [WordBits-1:0] flags_word_in;
  } req_t;

  typedef struct packed {
    logic                condition_true;
    logic [WordBits-1:0] flags_word_out;
  } rsp_t;

  function automatic logic [6:0] size_width(logic [1:0] code);
    logic [6:0] w;
    w = 7'(8) << code;
    if (w > 7'(DataWidth)) w = 7'(DataWidth);
    return w;
  endfunction

  function automatic logic [WordBits-1:0] size_mask(logic [6:0] w);
    logic [WordBits-1:0] m;
    if (w >= 7'(WordBits)) m = '1;
    else m = (WordBits'(1) << w) - WordBits'(1);
    return m;
  endfunction

endpackage

// ===== src/x86f_req_if.sv =====
// Request channel interface of the x86 flags unit.
// Depends on x86f_pkg.
`timescale 1ns / 1ps

interface x86f_req_if;
  logic                            valid;
  logic                            ready;
  logic [2:0]                      action;
  logic [1:0]                      operand_size;
  logic [x86f_pkg::WordBits-1:0]   left_operand;
  logic [x86f_pkg::WordBits-1:0]   right_operand;
  logic [x86f_pkg::WordBits-1:0]   result_value;
  logic                            keep_carry;
  logic                            zero_from_compare;
  logic [3:0]                      condition_code;
  logic [x86f_pkg::WordBits-1:0]   flags_word_in;

  modport source (
    output valid, action, operand_size, left_operand, right_operand, result_value,
           keep_carry, zero_from_compare, condition_code, flags_word_in,
    input  ready
  );
  modport sink (
    input  valid, action, operand_size, left_operand, right_operand, result_value,
           keep_carry, zero_from_compare, condition_code, flags_word_in,
    output ready
  );
endinterface

// ===== src/x86f_rsp_if.sv =====
// Response channel interface of the x86 flags unit.
// Depends on x86f_pkg.
`timescale 1ns / 1ps

interface x86f_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          condition_true;
  logic [x86f_pkg::WordBits-1:0] flags_word_out;

  modport source (output valid, condition_true, flags_word_out, input ready);
  modport sink (input valid, condition_true, flags_word_out, output ready);
endinterface

// ===== src/x86_flags_unit.sv =====
// Top level of the x86 flags unit: input register, flag register, output register.
// Depends on x86f_pkg, x86f_req_if, x86f_rsp_if, x86f_eval, x86_flags_unit_assert.svh.
`timescale 1ns / 1ps

// Keeps the x86 status flags and serves one request word per cycle while the
// response side is ready: flag updates for add, sub and logic results,
// condition-code tests, and packing or unpacking of the flags word at 8 to 64
// bits. Each word is held in the input register, where it is evaluated against
// the current flags, and waits there while a response that has not been taken
// holds the output register; it then sits in the output register until taken.
// With the response side ready, a new request is taken every cycle. Flags change
// when a word moves into the output register, so each word sees the flags its
// predecessor left.

module x86_flags_unit (
  input logic       clk,
  input logic       rst,
  x86f_req_if.sink   req,
  x86f_rsp_if.source rsp
);

  `include "x86_flags_unit_assert.svh"

  logic             stage_valid;
  x86f_pkg::req_t   item;
  logic             out_valid;
  x86f_pkg::rsp_t   out_data;
  x86f_pkg::flags_t flags;
  x86f_pkg::flags_t flags_next;
  x86f_pkg::rsp_t   result;
  logic             advance;
  logic             fire;

  x86f_eval u_eval (
    .item       (item),
    .flags      (flags),
    .flags_next (flags_next),
    .result     (result)
  );

  assign advance = !out_valid || rsp.ready;
  assign fire = stage_valid && advance;
  assign req.ready = !stage_valid || advance;

  assign rsp.valid = out_valid;
  assign rsp.condition_true = out_data.condition_true;
  assign rsp.flags_word_out = out_data.flags_word_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (req.ready) begin
      stage_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      item.action <= req.action;
      item.operand_size <= req.operand_size;
      item.left_operand <= req.left_operand;
      item.right_operand <= req.right_operand;
      item.result_value <= req.result_value;
      item.keep_carry <= req.keep_carry;
      item.zero_from_compare <= req.zero_from_compare;
      item.condition_code <= req.condition_code;
      item.flags_word_in <= req.flags_word_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '0;
    end else if (fire) begin
      flags <= flags_next;
    end
  end

  `X86F_ASSERT_NEXT(a_flags_hold, !fire, $stable(flags), "flags changed with no word retired")
  `X86F_ASSERT_NEXT(a_stage_hold, stage_valid && !advance, stage_valid, "stalled word dropped")
  `X86F_ASSERT_NOW(a_ready_full, !req.ready, stage_valid && out_valid, "stall with free slot")

endmodule

// ===== src/x86f_eval.sv =====
// Flag evaluation for one word: next flags and response from current flags.
// Depends on x86f_pkg.
`timescale 1ns / 1ps

module x86f_eval (
  input  x86f_pkg::req_t   item,
  input  x86f_pkg::flags_t flags,
  output x86f_pkg::flags_t flags_next,
  output x86f_pkg::rsp_t   result
);

  logic [6:0]                    width;
  logic [5:0]                    top;
  logic [x86f_pkg::WordBits-1:0] mask;
  logic [x86f_pkg::WordBits-1:0] lhs;
  logic [x86f_pkg::WordBits-1:0] rhs;
  logic [x86f_pkg::WordBits-1:0] res;
  logic [x86f_pkg::WordBits-1:0] add_ov;
  logic [x86f_pkg::WordBits-1:0] packed_word;
  logic                          sign;
  logic                          parity;
  logic                          lhs_lt_rhs;
  logic                          signed_lt;
  logic                          test;

  always_comb begin
    width = x86f_pkg::size_width(item.operand_size);
    top = 6'(width - 7'd1);
    mask = x86f_pkg::size_mask(width);
    lhs = item.left_operand & mask;
    rhs = item.right_operand & mask;
    res = item.result_value & mask;
    add_ov = (res ^ lhs) & (res ^ rhs);
    sign = res[top];
    parity = ~(^res[7:0]);
    lhs_lt_rhs = lhs < rhs;
    signed_lt = (lhs[top] != rhs[top]) ? lhs[top] : lhs_lt_rhs;

    packed_word = x86f_pkg::FlagsFixedBits;
    packed_word[x86f_pkg::CfPos] = flags.cf;
    packed_word[x86f_pkg::PfPos] = flags.pf;
    packed_word[x86f_pkg::AfPos] = flags.af;
    packed_word[x86f_pkg::ZfPos] = flags.zf;
    packed_word[x86f_pkg::SfPos] = flags.sf;
    packed_word[x86f_pkg::DfPos] = flags.df;
    packed_word[x86f_pkg::OfPos] = flags.of;

    unique case (x86f_pkg::cond_test_t'(item.condition_code[3:1]))
      x86f_pkg::TestO:  test = flags.of;
      x86f_pkg::TestC:  test = flags.cf;
      x86f_pkg::TestZ:  test = flags.zf;
      x86f_pkg::TestBe: test = flags.cf | flags.zf;
      x86f_pkg::TestS:  test = flags.sf;
      x86f_pkg::TestP:  test = flags.pf;
      x86f_pkg::TestL:  test = flags.sf ^ flags.of;
      x86f_pkg::TestLe: test = flags.zf | (flags.sf ^ flags.of);
      default:          test = 1'b0;
    endcase
  end

  always_comb begin
    flags_next = flags;
    result = '0;
    unique case (item.action)
      x86f_pkg::ActAdd: begin
        flags_next.sf = sign;
        flags_next.pf = parity;
        flags_next.af = res[4] ^ lhs[4] ^ rhs[4];
        flags_next.zf = (res == '0);
        if (!item.keep_carry) flags_next.cf = res < lhs;
        flags_next.of = add_ov[top];
      end
      x86f_pkg::ActSub: begin
        flags_next.sf = sign;
        flags_next.pf = parity;
        flags_next.af = res[4] ^ lhs[4] ^ rhs[4];
        flags_next.zf = item.zero_from_compare ? (lhs == rhs) : (res == '0);
        if (!item.keep_carry) flags_next.cf = lhs_lt_rhs;
        flags_next.of = sign ^ signed_lt;
      end
      x86f_pkg::ActLogic: begin
        flags_next.sf = sign;
        flags_next.pf = parity;
        flags_next.af = 1'b0;
      end
      x86f_pkg::ActCond: begin
        result.condition_true = test ^ item.condition_code[0];
      end
      x86f_pkg::ActRead: begin
        result.flags_word_out = packed_word & mask;
      end
      x86f_pkg::ActWrite: begin
        if (width > 7'(x86f_pkg::CfPos)) flags_next.cf = item.flags_word_in[x86f_pkg::CfPos];
        if (width > 7'(x86f_pkg::PfPos)) flags_next.pf = item.flags_word_in[x86f_pkg::PfPos];
        if (width > 7'(x86f_pkg::AfPos)) flags_next.af = item.flags_word_in[x86f_pkg::AfPos];
        if (width > 7'(x86f_pkg::ZfPos)) flags_next.zf = item.flags_word_in[x86f_pkg::ZfPos];
        if (width > 7'(x86f_pkg::SfPos)) flags_next.sf = item.flags_word_in[x86f_pkg::SfPos];
        if (width > 7'(x86f_pkg::DfPos)) flags_next.df = item.flags_word_in[x86f_pkg::DfPos];
        if (width > 7'(x86f_pkg::OfPos)) flags_next.of = item.flags_word_in[x86f_pkg::OfPos];
      end
      default: begin
        flags_next = flags;
      end
    endcase
  end

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for x86_flags_unit: directed table, then random words in three
// idling phases; responses checked against table values or an in-bench flags model.
// Depends on x86f_pkg, x86f_req_if, x86f_rsp_if and the x86_flags_unit RTL.
`timescale 1ns / 1ps

module testbench;
  import x86f_pkg::*;

  localparam logic [2:0] ActSpare6 = 3'd6;
  localparam logic [2:0] ActSpare7 = 3'd7;
  localparam logic [1:0] SizeB = 2'd0;
  localparam logic [1:0] SizeW = 2'd1;
  localparam logic [1:0] SizeD = 2'd2;
  localparam logic [1:0] SizeQ = 2'd3;
  localparam int RandomPerPhase = 250;
  localparam int HoldCycles = 40;
  localparam int StallLimit = 1000;

  typedef struct {
    req_t w;
    bit   typed;
    rsp_t want;
  } stim_row_t;

  logic clk;
  logic rst;

  x86f_req_if req ();
  x86f_rsp_if rsp ();

  x86_flags_unit dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  flags_t    arch_flags;
  rsp_t      flag_results_q[$];
  stim_row_t plan[$];
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  int        words_taken = 0;
  int        hold_start = 1 << 30;
  int        hold_left = 0;
  bit        hold_done = 0;
  int        stall_cycles = 0;
  int        mismatches = 0;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic rsp_t apply_flag_action(input req_t w);
    int unsigned bits;
    logic [63:0] m, lhs, rhs, res, ovf, packed_flags;
    logic        slt, t;
    rsp_t        r;
    bits = 8 << w.operand_size;
    m = (bits == 64) ? '1 : ((64'd1 << bits) - 64'd1);
    lhs = w.left_operand & m;
    rhs = w.right_operand & m;
    res = w.result_value & m;
    r = '0;
    case (w.action)
      ActAdd, ActSub: begin
        arch_flags.sf = res[bits-1];
        arch_flags.pf = ~^res[7:0];
        arch_flags.af = res[4] ^ lhs[4] ^ rhs[4];
        if (w.action == ActAdd) begin
          arch_flags.zf = (res == 64'd0);
          if (!w.keep_carry) arch_flags.cf = (res < lhs);
          ovf = (res ^ lhs) & (res ^ rhs);
          arch_flags.of = ovf[bits-1];
        end else begin
          slt = (lhs[bits-1] != rhs[bits-1]) ? lhs[bits-1] : (lhs < rhs);
          arch_flags.zf = w.zero_from_compare ? (lhs == rhs) : (res == 64'd0);
          if (!w.keep_carry) arch_flags.cf = (lhs < rhs);
          arch_flags.of = (arch_flags.sf != slt);
        end
      end
      ActLogic: begin
        arch_flags.sf = res[bits-1];
        arch_flags.pf = ~^res[7:0];
        arch_flags.af = 1'b0;
      end
      ActCond: begin
        case (cond_test_t'(w.condition_code[3:1]))
          TestO:  t = arch_flags.of;
          TestC:  t = arch_flags.cf;
          TestZ:  t = arch_flags.zf;
          TestBe: t = arch_flags.cf | arch_flags.zf;
          TestS:  t = arch_flags.sf;
          TestP:  t = arch_flags.pf;
          TestL:  t = arch_flags.sf ^ arch_flags.of;
          default: t = arch_flags.zf | (arch_flags.sf ^ arch_flags.of);
        endcase
        r.condition_true = t ^ w.condition_code[0];
      end
      ActRead: begin
        packed_flags = FlagsFixedBits;
        packed_flags[CfPos] = arch_flags.cf;
        packed_flags[PfPos] = arch_flags.pf;
        packed_flags[AfPos] = arch_flags.af;
        packed_flags[ZfPos] = arch_flags.zf;
        packed_flags[SfPos] = arch_flags.sf;
        packed_flags[DfPos] = arch_flags.df;
        packed_flags[OfPos] = arch_flags.of;
        r.flags_word_out = packed_flags & m;
      end
      ActWrite: begin
        if (bits > CfPos) arch_flags.cf = w.flags_word_in[CfPos];
        if (bits > PfPos) arch_flags.pf = w.flags_word_in[PfPos];
        if (bits > AfPos) arch_flags.af = w.flags_word_in[AfPos];
        if (bits > ZfPos) arch_flags.zf = w.flags_word_in[ZfPos];
        if (bits > SfPos) arch_flags.sf = w.flags_word_in[SfPos];
        if (bits > DfPos) arch_flags.df = w.flags_word_in[DfPos];
        if (bits > OfPos) arch_flags.of = w.flags_word_in[OfPos];
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic req_t make_word(input logic [2:0] action, input logic [1:0] size,
                                     input logic [63:0] lhs, input logic [63:0] rhs,
                                     input logic [63:0] res, input logic keep,
                                     input logic zfc, input logic [3:0] cc,
                                     input logic [63:0] flags_word);
    req_t w;
    w.action = action;
    w.operand_size = size;
    w.left_operand = lhs;
    w.right_operand = rhs;
    w.result_value = res;
    w.keep_carry = keep;
    w.zero_from_compare = zfc;
    w.condition_code = cc;
    w.flags_word_in = flags_word;
    return w;
  endfunction

  function automatic stim_row_t row(input req_t w, input bit typed = 1'b0,
                                    input rsp_t want = '0);
    stim_row_t r;
    r.w = w;
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  function automatic logic [63:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return 64'd0;
      1: return '1;
      2: return {8{8'h80}};
      3: return {8{8'h7F}};
      4: return {4{16'h7FFF}};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic req_t random_word();
    int    pick;
    req_t  w;
    pick = $urandom_range(0, 99);
    w.action = (pick < 30) ? ActAdd : (pick < 55) ? ActSub : (pick < 67) ? ActLogic :
               (pick < 82) ? ActCond : (pick < 90) ? ActRead : (pick < 97) ? ActWrite :
               ($urandom_range(0, 1) ? ActSpare6 : ActSpare7);
    w.operand_size = 2'($urandom_range(0, 3));
    w.left_operand = pick_operand();
    w.right_operand = pick_operand();
    w.keep_carry = 1'($urandom_range(0, 1));
    w.zero_from_compare = 1'($urandom_range(0, 1));
    w.condition_code = 4'($urandom_range(0, 15));
    w.flags_word_in = ($urandom_range(0, 3) == 0) ? pick_operand() : {$urandom, $urandom};
    w.result_value = {$urandom, $urandom};
    if ($urandom_range(0, 4) != 0) begin
      case (w.action)
        ActAdd:   w.result_value = w.left_operand + w.right_operand;
        ActSub:   w.result_value = w.left_operand - w.right_operand;
        ActLogic: w.result_value = $urandom_range(0, 1) ? (w.left_operand & w.right_operand)
                                                         : (w.left_operand ^ w.right_operand);
        default: ;
      endcase
    end
    return w;
  endfunction

  task automatic send_word(input stim_row_t r);
    rsp_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req.valid = 1'b0;
      @(negedge clk);
    end
    req.valid = 1'b1;
    req.action = r.w.action;
    req.operand_size = r.w.operand_size;
    req.left_operand = r.w.left_operand;
    req.right_operand = r.w.right_operand;
    req.result_value = r.w.result_value;
    req.keep_carry = r.w.keep_carry;
    req.zero_from_compare = r.w.zero_from_compare;
    req.condition_code = r.w.condition_code;
    req.flags_word_in = r.w.flags_word_in;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    predicted = apply_flag_action(r.w);
    flag_results_q.push_back(r.typed ? r.want : predicted);
    words_taken++;
    @(negedge clk);
  endtask

  task automatic note_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s mismatch, expected %h, got %h", $realtime, what, want, got);
  endtask

  always @(negedge clk) begin
    if (hold_left > 0) begin
      rsp.ready = 1'b0;
      hold_left--;
    end else if (!hold_done && words_taken >= hold_start) begin
      hold_done = 1'b1;
      hold_left = HoldCycles - 1;
      rsp.ready = 1'b0;
    end else begin
      rsp.ready = ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      stall_cycles = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (flag_results_q.size() == 0) begin
          note_mismatch("unexpected response", 64'd0, rsp.flags_word_out);
        end else begin
          want = flag_results_q.pop_front();
          if (rsp.condition_true !== want.condition_true)
            note_mismatch("condition_true", 64'(want.condition_true),
                          64'(rsp.condition_true));
          if (rsp.flags_word_out !== want.flags_word_out)
            note_mismatch("flags_word_out", want.flags_word_out, rsp.flags_word_out);
        end
      end
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) stall_cycles = 0;
      else stall_cycles++;
    end
  end

  initial begin
    while (stall_cycles < StallLimit) @(posedge clk);
    $display("testbench NOT OK");
    $finish;
  end

  initial begin
    rst = 1'b1;
    arch_flags = '0;
    req.valid = 1'b0;
    req.action = ActAdd;
    req.operand_size = SizeB;
    req.left_operand = '0;
    req.right_operand = '0;
    req.result_value = '0;
    req.keep_carry = 1'b0;
    req.zero_from_compare = 1'b0;
    req.condition_code = '0;
    req.flags_word_in = '0;
    rsp.ready = 1'b0;

    plan.push_back(row(make_word(ActRead, SizeQ, '0, '0, '0, 0, 0, '0, '0), 1,
                       rsp_t'{1'b0, 64'h202}));
    plan.push_back(row(make_word(ActCond, SizeQ, '0, '0, '0, 0, 0, {TestO, 1'b0}, '0), 1,
                       rsp_t'{1'b0, 64'h0}));
    plan.push_back(row(make_word(ActCond, SizeQ, '0, '0, '0, 0, 0, {TestO, 1'b1}, '0), 1,
                       rsp_t'{1'b1, 64'h0}));
    plan.push_back(row(make_word(ActWrite, SizeQ, '0, '0, '0, 0, 0, '0, '1), 1,
                       rsp_t'{1'b0, 64'h0}));
    plan.push_back(row(make_word(ActRead, SizeQ, '0, '0, '0, 0, 0, '0, '0), 1,
                       rsp_t'{1'b0, 64'hED7}));
    plan.push_back(row(make_word(ActRead, SizeB, '1, '1, '1, 1, 1, '1, '1), 1,
                       rsp_t'{1'b0, 64'hD7}));
    plan.push_back(row(make_word(ActCond, SizeQ, '0, '0, '0, 0, 0, {TestLe, 1'b1}, '0)));
    plan.push_back(row(make_word(ActWrite, SizeB, '1, '1, '1, 1, 1, '1, 64'h0), 1,
                       rsp_t'{1'b0, 64'h0}));
    plan.push_back(row(make_word(ActRead, SizeW, '0, '0, '0, 0, 0, '0, '0), 1,
                       rsp_t'{1'b0, 64'hE02}));
    plan.push_back(row(make_word(ActAdd, SizeB, '1, 64'h1, 64'h0, 0, 0, '0, '0)));
    plan.push_back(row(make_word(ActCond, SizeB, '0, '0, '0, 0, 0, {TestC, 1'b0}, '0)));
    plan.push_back(row(make_word(ActAdd, SizeQ, '1, '1, ~64'h1, 1, 0, '0, '0)));
    plan.push_back(row(make_word(ActRead, SizeQ, '0, '0, '0, 0, 0, '0, '0)));
    plan.push_back(row(make_word(ActSub, SizeW, 64'h8000, 64'h1, 64'h7FFF, 0, 0, '0, '0)));
    plan.push_back(row(make_word(ActCond, SizeW, '0, '0, '0, 0, 0, {TestL, 1'b0}, '0)));
    plan.push_back(row(make_word(ActSub, SizeD, 64'h5, 64'h5, 64'h1, 0, 1, '0, '0)));
    plan.push_back(row(make_word(ActCond, SizeD, '0, '0, '0, 0, 0, {TestZ, 1'b0}, '0)));
    plan.push_back(row(make_word(ActSub, SizeQ, 64'h0, '1, 64'h1, 0, 0, '0, '0)));
    plan.push_back(row(make_word(ActLogic, SizeQ, '0, '0, {1'b1, 63'h0}, 0, 0, '0, '0)));
    plan.push_back(row(make_word(ActRead, SizeD, '0, '0, '0, 0, 0, '0, '0)));
    plan.push_back(row(make_word(ActSpare6, SizeQ, '1, '1, '1, 1, 1, '1, '1), 1,
                       rsp_t'{1'b0, 64'h0}));
    plan.push_back(row(make_word(ActSpare7, SizeQ, '1, '1, '1, 1, 1, '1, '1), 1,
                       rsp_t'{1'b0, 64'h0}));
    plan.push_back(row(make_word(ActCond, SizeQ, '0, '0, '0, 0, 0, {TestP, 1'b1}, '0)));
    plan.push_back(row(make_word(ActCond, SizeQ, '0, '0, '0, 0, 0, {TestBe, 1'b0}, '0)));
    plan.push_back(row(make_word(ActCond, SizeQ, '0, '0, '0, 0, 0, {TestS, 1'b1}, '0)));
    hold_start = plan.size() + 2 * RandomPerPhase + 30;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_idle_pct = 6;
    recv_idle_pct = 86;
    foreach (plan[i]) send_word(plan[i]);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 86 : 0;
      recv_idle_pct = (phase == 0) ? 86 : (phase == 1) ? 6 : 0;
      if (phase == 1) begin
        req.valid = 1'b0;
        while (flag_results_q.size() != 0) @(negedge clk);
      end
      for (int i = 0; i < RandomPerPhase; i++) send_word(row(random_word()));
    end

    req.valid = 1'b0;
    while (flag_results_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
